// File: rtl/core/utf8_stream_decoder_core_assert.svh
// Assertion macros for the UTF-8 stream decoder.
// Each macro expects clk and rst_n in scope.
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define U8SD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define U8SD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define U8SD_ASSERT_IMP(label, ante, cons, msg)
`define U8SD_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/core/u8sd_pkg.sv
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam logic [30:0] REPLACEMENT  = 31'h0000_FFFD;
    localparam logic [30:0] SURR_LO      = 31'h0000_D800;
    localparam logic [30:0] SURR_HI      = 31'h0000_DFFF;
    localparam logic [30:0] NONCHAR_FFFE = 31'h0000_FFFE;
    localparam logic [30:0] NONCHAR_FFFF = 31'h0000_FFFF;
    localparam logic [30:0] LIM_2BYTE    = 31'h0000_0800;
    localparam logic [30:0] LIM_3BYTE    = 31'h0001_0000;
    localparam logic [30:0] LIM_4BYTE    = 31'h0020_0000;
    localparam logic [30:0] LIM_5BYTE    = 31'h0400_0000;
    localparam logic [7:0]  LEAD_MIN     = 8'hC0;
    localparam logic [7:0]  LEAD_MAX     = 8'hFD;
    localparam logic [7:0]  CONT_MAX     = 8'hBF;
    localparam logic [2:0]  CNT_IDLE     = 3'd0;
    localparam logic [2:0]  CNT_ONE      = 3'd1;
    localparam logic [2:0]  CNT_MAXLEN   = 3'd6;
    localparam logic [2:0]  CNT_OVERRUN  = 3'd7;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic [30:0] code_point;
        logic        malformed;
        logic        last_of_text;
    } out_word_t;

    typedef struct packed {
        logic [30:0] code_point;
        logic        malformed;
    } dec_t;

    // Count of leading one bits, 0..8.
    function automatic logic [3:0] leading_ones(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            if (run && b[i]) begin
                n = n + 4'd1;
            end
            else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

    function automatic logic [2:0] shortest_len(input logic [30:0] v);
        logic [2:0] len;
        if (v < 31'h80) begin
            len = 3'd1;
        end
        else if (v < LIM_2BYTE) begin
            len = 3'd2;
        end
        else if (v < LIM_3BYTE) begin
            len = 3'd3;
        end
        else if (v < LIM_4BYTE) begin
            len = 3'd4;
        end
        else if (v < LIM_5BYTE) begin
            len = 3'd5;
        end
        else begin
            len = 3'd6;
        end
        return len;
    endfunction

    // Check the held sequence and give its code point or the replacement.
    function automatic dec_t decode_seq(
        input logic [7:0]  lead,
        input logic [30:0] acc,
        input logic [2:0]  cnt,
        input logic        badc
    );
        dec_t r;
        logic bad;
        if (cnt == CNT_ONE) begin
            bad = lead[7];
        end
        else if (cnt == CNT_IDLE || cnt == CNT_OVERRUN) begin
            bad = 1'b1;
        end
        else begin
            bad = (lead < LEAD_MIN) || (lead > LEAD_MAX) || badc
                || ({1'b0, cnt} != leading_ones(lead))
                || ((acc >= SURR_LO) && (acc <= SURR_HI))
                || (acc == NONCHAR_FFFE) || (acc == NONCHAR_FFFF)
                || (shortest_len(acc) != cnt);
        end
        r.malformed  = bad;
        r.code_point = bad ? REPLACEMENT : acc;
        return r;
    endfunction

endpackage

// File: rtl/core/utf8_stream_decoder_core.sv
`timescale 1ns / 1ps

// UTF-8 stream decoder (old 1-to-6-byte form). Takes one byte per word on the
// input channel, with end_of_text marking the last byte of a text, and emits
// one word per decoded code point; a rejected sequence comes out as U+FFFD
// with malformed set. A sequence is emitted when the next plain or lead byte
// arrives, or at end of text, where the word carrying last_of_text is the flush.
// A byte is taken every cycle while in_ready is high: the sequence state is
// updated in one pass and the decoded words are registered into a three-entry
// result queue whose head drives the output. in_ready is high while the queue
// holds at most one word, so a byte that closes a sequence and ends the text
// (two words) can hold in_ready low until the queue drains; with out_ready held
// high and at most one word per byte the input never stalls.
`include "utf8_stream_decoder_core_assert.svh"

module utf8_stream_decoder_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  u8sd_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output u8sd_pkg::out_word_t  out_data
);

    import u8sd_pkg::*;

    localparam int QDEPTH = 3;

    // Open sequence state
    logic [7:0]  lead_reg,  lead_next;
    logic [30:0] acc_reg,   acc_next;
    logic [2:0]  cnt_reg,   cnt_next;
    logic        badc_reg,  badc_next;

    // Result queue, head in slot 0
    out_word_t   q_reg  [QDEPTH];
    out_word_t   q_next [QDEPTH];
    logic [1:0]  qcnt_reg, qcnt_next;

    logic        in_acc;
    logic        pop;
    logic        opens;
    logic        closes;
    logic        eot;
    logic [7:0]  b;
    logic [3:0]  lones;
    logic [2:0]  lones_sat;
    logic [2:0]  cnt_inc;
    logic [7:0]  upd_lead;
    logic [30:0] upd_acc;
    logic [2:0]  upd_cnt;
    logic        upd_badc;
    dec_t        dec_close;
    dec_t        dec_flush;
    out_word_t   res_first;
    out_word_t   res_second;
    logic [1:0]  push_n;
    logic [1:0]  base;

    assign in_ready  = (qcnt_reg <= 2'd1);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = (qcnt_reg != 2'd0);
    assign out_data  = q_reg[0];
    assign pop       = out_valid && out_ready;

    assign b   = in_data.byte_in;
    assign eot = in_data.end_of_text;

    // A plain byte or a lead byte opens a new sequence; so does anything at idle.
    assign opens  = (b < 8'h80) || ((b >= LEAD_MIN) && (b <= LEAD_MAX))
                  || (cnt_reg == CNT_IDLE);
    assign closes = opens && (cnt_reg != CNT_IDLE);

    assign lones     = leading_ones(b);
    assign lones_sat = (lones > 4'd7) ? 3'd7 : lones[2:0];
    assign cnt_inc   = (cnt_reg == CNT_OVERRUN) ? CNT_OVERRUN : cnt_reg + 3'd1;

    // State after this byte, before any end-of-text flush
    always_comb
    begin
        if (opens)
        begin
            upd_lead = b;
            upd_acc  = {23'd0, b & (8'h7F >> lones_sat)};
            upd_cnt  = CNT_ONE;
            upd_badc = 1'b0;
        end
        else
        begin
            upd_lead = lead_reg;
            upd_cnt  = cnt_inc;
            // Drop payload bits once the run passes six bytes
            upd_acc  = (cnt_inc <= CNT_MAXLEN) ? {acc_reg[24:0], b[5:0]} : acc_reg;
            upd_badc = badc_reg || (b > CONT_MAX);
        end
    end

    assign dec_close = decode_seq(lead_reg, acc_reg, cnt_reg, badc_reg);
    assign dec_flush = decode_seq(upd_lead, upd_acc, upd_cnt, upd_badc);

    // Order the words of this byte: the closed sequence first, the flush after.
    always_comb
    begin
        res_second.code_point   = dec_flush.code_point;
        res_second.malformed    = dec_flush.malformed;
        res_second.last_of_text = 1'b1;
        if (closes)
        begin
            res_first.code_point   = dec_close.code_point;
            res_first.malformed    = dec_close.malformed;
            res_first.last_of_text = 1'b0;
        end
        else
        begin
            res_first = res_second;
        end
    end

    assign push_n = in_acc ? ({1'b0, closes} + {1'b0, eot}) : 2'd0;
    assign base   = qcnt_reg - {1'b0, pop};

    always_comb
    begin
        if (in_acc && eot)
        begin
            // Flush returns the decoder to idle
            lead_next = 8'd0;
            acc_next  = 31'd0;
            cnt_next  = CNT_IDLE;
            badc_next = 1'b0;
        end
        else if (in_acc)
        begin
            lead_next = upd_lead;
            acc_next  = upd_acc;
            cnt_next  = upd_cnt;
            badc_next = upd_badc;
        end
        else
        begin
            lead_next = lead_reg;
            acc_next  = acc_reg;
            cnt_next  = cnt_reg;
            badc_next = badc_reg;
        end
    end

    // Shift the queue down on a pop, then write new words behind what remains.
    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && (i < QDEPTH - 1))
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if ((push_n != 2'd0) && (2'(i) == base))
            begin
                q_next[i] = res_first;
            end
            if ((push_n == 2'd2) && (2'(i) == base + 2'd1))
            begin
                q_next[i] = res_second;
            end
        end
        qcnt_next = base + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= 8'd0;
            acc_reg  <= 31'd0;
            cnt_reg  <= CNT_IDLE;
            badc_reg <= 1'b0;
            qcnt_reg <= 2'd0;
        end
        else
        begin
            lead_reg <= lead_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            badc_reg <= badc_next;
            qcnt_reg <= qcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    `U8SD_ASSERT_NXT(a_eot_idles, in_acc && eot, cnt_reg == CNT_IDLE, "sequence open after end of text")
    `U8SD_ASSERT_NXT(a_byte_opens, in_acc && !eot, cnt_reg != CNT_IDLE, "no sequence open after a byte")
    `U8SD_ASSERT_IMP(a_bad_repl, out_valid && out_data.malformed, out_data.code_point == REPLACEMENT, "malformed word without replacement")
    `U8SD_ASSERT_IMP(a_no_surr, out_valid && !out_data.malformed, (out_data.code_point < SURR_LO) || (out_data.code_point > SURR_HI), "surrogate passed as valid")
    `U8SD_ASSERT_NXT(a_eot_word, in_acc && eot, out_valid, "no flush word after end of text")

endmodule

// File: tb/utf8_stream_decoder_core_tb.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_core_tb;

    import u8sd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RESET_CYCLES = 9;
    localparam int PHASE_BYTES  = 340;
    localparam int MAX_REPORTS  = 10;
    localparam int TAIL_CYCLES  = 16;

    // One row of the directed text: the byte, its end-of-text flag and, where
    // the answer is obvious, the flush word typed in by hand.
    typedef struct packed {
        logic [7:0]  b;
        logic        eot;
        logic        typed;
        logic [30:0] cp;
        logic        mal;
    } text_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    // Shadow of the decoder's sequence state.
    logic [7:0]  dec_lead;
    logic [30:0] dec_bits;
    logic [2:0]  dec_len;
    logic        dec_badc;

    out_word_t   step_out[$];     // words caused by the byte just taken
    out_word_t   pending_cps[$];  // decoded words still owed by the block
    text_row_t   text_rows[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int bytes_sent     = 0;
    int snd_idle_pct   = 0;
    int rcv_idle_pct   = 0;

    utf8_stream_decoder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder shadow
    // ------------------------------------------------------------------

    // Number of leading one bits of a byte, 0..8.
    function automatic int lead_run(input logic [7:0] b);
        int n;
        n = 0;
        while (n < 8 && b[7 - n])
            n++;
        return n;
    endfunction

    // Length of the shortest old-style encoding of a value.
    function automatic int min_len(input logic [30:0] v);
        if (v < 31'h80) return 1;
        if (v < LIM_2BYTE) return 2;
        if (v < LIM_3BYTE) return 3;
        if (v < LIM_4BYTE) return 4;
        if (v < LIM_5BYTE) return 5;
        return 6;
    endfunction

    // Judge the held sequence: its code point, or the replacement if rejected.
    function automatic out_word_t judge_seq(input logic last);
        out_word_t   r;
        logic        ok;
        logic [30:0] value;
        if (dec_len == CNT_ONE)
        begin
            // a lone byte stands only if it is plain ASCII
            value = {23'd0, dec_lead};
            ok    = (dec_lead < 8'h80);
        end
        else
        begin
            value = dec_bits;
            ok    = (dec_len >= 3'd2) && (dec_len <= CNT_MAXLEN)
                && (dec_lead >= LEAD_MIN) && (dec_lead <= LEAD_MAX)
                && !dec_badc
                && (lead_run(dec_lead) == int'(dec_len))
                && !((value >= SURR_LO) && (value <= SURR_HI))
                && (value != NONCHAR_FFFE) && (value != NONCHAR_FFFF)
                && (min_len(value) == int'(dec_len));
        end
        r.code_point   = ok ? value : REPLACEMENT;
        r.malformed    = !ok;
        r.last_of_text = last;
        return r;
    endfunction

    task automatic clear_decoder();
        dec_lead = 8'd0;
        dec_bits = 31'd0;
        dec_len  = CNT_IDLE;
        dec_badc = 1'b0;
    endtask

    // Advance the shadow by one byte and collect the words it causes.
    task automatic advance_decoder(input in_word_t w);
        int         n;
        logic [7:0] b;
        b = w.byte_in;
        step_out.delete();
        if (b < 8'h80 || (b >= LEAD_MIN && b <= LEAD_MAX) || dec_len == CNT_IDLE)
        begin
            // close any open sequence, then open a fresh one led by this byte
            if (dec_len != CNT_IDLE)
                step_out = {step_out, judge_seq(1'b0)};
            n        = lead_run(b);
            dec_lead = b;
            dec_bits = {23'd0, b & (8'h7F >> ((n > 7) ? 7 : n))};
            dec_len  = CNT_ONE;
            dec_badc = 1'b0;
        end
        else
        begin
            // extend: saturate the count, stop gathering bits past six bytes
            if (dec_len < CNT_OVERRUN)
                dec_len = dec_len + 3'd1;
            if (dec_len <= CNT_MAXLEN)
                dec_bits = {dec_bits[24:0], b[5:0]};
            if (b > CONT_MAX)
                dec_badc = 1'b1;
        end
        if (w.end_of_text)
        begin
            step_out = {step_out, judge_seq(1'b1)};
            clear_decoder();
        end
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Present one byte word from a falling edge and hold it until taken. A
    // typed row replaces the flush word with the one written in the table.
    task automatic send_word(input in_word_t w, input logic typed,
                             input out_word_t typed_res);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_decoder(w);
        for (int i = 0; i < step_out.size(); i++)
        begin
            if (typed && i == step_out.size() - 1)
                pending_cps = {pending_cps, typed_res};
            else
                pending_cps = {pending_cps, step_out[i]};
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold off until every owed word has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_cps.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] range_lo(input int len);
        if (len == 1) return 32'd0;
        if (len == 2) return 32'h80;
        return 32'd1 << (5 * len - 4);
    endfunction

    // Byte idx of the old-style encoding of v in len bytes, overlong or not.
    function automatic logic [7:0] enc_byte(input logic [30:0] v, input int len,
                                            input int idx);
        logic [30:0] part;
        if (len == 1) return {1'b0, v[6:0]};
        part = v >> (6 * (len - 1 - idx));
        if (idx == 0) return (8'hFF << (8 - len)) | (part[7:0] & (8'h7F >> len));
        return {2'b10, part[5:0]};
    endfunction

    // One random stretch of text: mostly proper encodings with random content,
    // else overlong forms, runs with a random number of trailing bytes, or noise.
    task automatic send_text_piece();
        logic [7:0]  piece[$];
        in_word_t    w;
        int          kind;
        int          len;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [30:0] v;
        kind = $urandom_range(0, 99);
        len  = 0;
        if (kind < 60)
        begin
            len = $urandom_range(1, 6);
            lo  = range_lo(len);
            hi  = range_lo(len + 1) - 32'd1;
            case ($urandom_range(0, 9))
                0: v = lo[30:0];
                1: v = hi[30:0];
                2: v = (len == 3) ? 31'($urandom_range(SURR_HI, SURR_LO)) : lo[30:0];
                3: v = (len == 3) ? 31'($urandom_range(NONCHAR_FFFF, NONCHAR_FFFE))
                                  : hi[30:0];
                default: v = 31'($urandom_range(hi, lo));
            endcase
        end
        else if (kind < 72)
        begin
            // value that fits a shorter form
            len = $urandom_range(2, 6);
            v   = 31'($urandom_range(range_lo(len) - 32'd1, 0));
        end
        else if (kind < 88)
        begin
            // lead with a random run of trailing bytes, now and then 0xFE/0xFF
            piece = {piece, 8'($urandom_range(LEAD_MIN, LEAD_MAX))};
            repeat ($urandom_range(0, 8))
            begin
                if ($urandom_range(0, 7) == 0)
                    piece = {piece, 8'($urandom_range(8'hFF, 8'hFE))};
                else
                    piece = {piece, 8'($urandom_range(CONT_MAX, 8'h80))};
            end
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                piece = {piece, 8'($urandom_range(0, 255))};
        end
        for (int i = 0; i < len; i++)
            piece = {piece, enc_byte(v, len, i)};
        for (int i = 0; i < piece.size(); i++)
        begin
            w.byte_in     = piece[i];
            w.end_of_text = (i == piece.size() - 1) ? ($urandom_range(0, 5) == 0)
                                                    : ($urandom_range(0, 49) == 0);
            send_word(w, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed text
    // ------------------------------------------------------------------

    task automatic row(input logic [7:0] b, input logic eot);
        text_row_t r;
        r         = '{b: b, eot: eot, typed: 1'b0, cp: 31'd0, mal: 1'b0};
        text_rows = {text_rows, r};
    endtask

    // End-of-text byte whose flush word is known at a glance.
    task automatic row_expect(input logic [7:0] b, input logic [30:0] cp,
                              input logic mal);
        text_row_t r;
        r         = '{b: b, eot: 1'b1, typed: 1'b1, cp: cp, mal: mal};
        text_rows = {text_rows, r};
    endtask

    task automatic build_rows();
        row_expect(8'h00, 31'h00, 1'b0);          // lowest byte, alone
        row_expect(8'hFF, REPLACEMENT, 1'b1);     // stray top byte at idle
        row(8'hC3, 1'b0);                         // two-byte e acute
        row_expect(8'hA9, 31'hE9, 1'b0);
        row(8'hC0, 1'b0);                         // overlong NUL
        row_expect(8'h80, REPLACEMENT, 1'b1);
        row(8'hED, 1'b0);                         // first high surrogate
        row(8'hA0, 1'b0);
        row_expect(8'h80, REPLACEMENT, 1'b1);
        row(8'hEF, 1'b0);                         // noncharacter U+FFFF
        row(8'hBF, 1'b0);
        row_expect(8'hBF, REPLACEMENT, 1'b1);
        row(8'hE2, 1'b0);                         // lead claims more, ASCII cuts it
        row(8'h82, 1'b0);
        row(8'h41, 1'b1);
        row(8'hC3, 1'b0);                         // lead claims fewer than present
        row(8'hA9, 1'b0);
        row_expect(8'hA9, REPLACEMENT, 1'b1);
        row(8'hFD, 1'b0);                         // top of the six-byte range,
        repeat (5)                                // closed by a top ASCII byte
            row(8'hBF, 1'b0);
        row(8'h7F, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    task automatic note_mismatch(input string what, input out_word_t want,
                                 input out_word_t got);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t %s: expected cp=%h mal=%b last=%b, got cp=%h mal=%b last=%b",
                     $time, what, want.code_point, want.malformed, want.last_of_text,
                     got.code_point, got.malformed, got.last_of_text);
        mismatch_count++;
    endtask

    // Compare every word taken against the oldest one owed.
    always @(posedge clk)
    begin : check_words
        out_word_t  want;
        logic [2:0] bad_fields;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cps.size() == 0)
            begin
                note_mismatch("word with nothing owed", '0, out_data);
            end
            else
            begin
                want       = pending_cps.pop_front();
                bad_fields = {out_data.code_point   !== want.code_point,
                              out_data.malformed    !== want.malformed,
                              out_data.last_of_text !== want.last_of_text};
                if (|bad_fields)
                    note_mismatch("wrong word", want, out_data);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("utf8_stream_decoder_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------

    initial
    begin
        in_word_t  w;
        out_word_t typed_res;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        clear_decoder();
        build_rows();
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed text, no idling on either side
        foreach (text_rows[i])
        begin
            w.byte_in              = text_rows[i].b;
            w.end_of_text          = text_rows[i].eot;
            typed_res.code_point   = text_rows[i].cp;
            typed_res.malformed    = text_rows[i].mal;
            typed_res.last_of_text = 1'b1;
            send_word(w, text_rows[i].typed, typed_res);
        end
        wait_drained();

        // random text in three idling phases; drain fully between them
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin snd_idle_pct = 29; rcv_idle_pct = 48; end
                1: begin snd_idle_pct = 48; rcv_idle_pct = 29; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES)
                send_text_piece();
            wait_drained();
        end

        // let any stray word show itself
        repeat (TAIL_CYCLES)
            @(negedge clk);

        if (mismatch_count == 0 && pending_cps.size() == 0)
            $display("utf8_stream_decoder_core: match");
        else
            $display("utf8_stream_decoder_core: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/u8sd_pkg.sv
rtl/core/utf8_stream_decoder_core.sv
tb/utf8_stream_decoder_core_tb.sv
